@@ rtl/rhsv_pkg.sv @@
// shared types and constants of the rgb to hsv converter
// no dependencies; imported by every other file in rtl
package rhsv_pkg;

  localparam int CHAN_W  = 8;    // width of one color channel
  localparam int DIV_W   = 8;    // divisor width of the long dividers
  localparam int HUE_W   = 15;   // hue result field
  localparam int SV_W    = 13;   // saturation and brightness result fields

  localparam int OFF_RED      = 360;
  localparam int OFF_GREEN    = 120;
  localparam int OFF_BLUE     = 240;
  localparam int HUE_SPAN     = 60;
  localparam int HUE_WRAP_DEG = 360;
  localparam int HUE_QMAX_DEG = 420;  // hue quotient never exceeds this many degrees
  localparam int PCT          = 100;
  localparam int CHAN_FULL    = 255;

  typedef struct packed {
    logic hue_zero;  // grey pixel, hue forced to zero
    logic sat_zero;  // black pixel, saturation forced to zero
  } rhsv_flags_t;

endpackage

@@ rtl/rhsv_front.sv @@
// front end: channel max/min/diff and sector pick, then divider operands and brightness
// two register stages; depends on rhsv_pkg
module rhsv_front
  import rhsv_pkg::*;
#(
  parameter int FRAC_BITS = 6,
  parameter int QW = 15
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [CHAN_W-1:0]        in_red,
  input  logic [CHAN_W-1:0]        in_green,
  input  logic [CHAN_W-1:0]        in_blue,
  output logic                     op_valid,
  output rhsv_flags_t              op_flags,
  output logic [QW+DIV_W-1:0]      hue_num,
  output logic [DIV_W-1:0]         hue_den,
  output logic [QW+DIV_W-1:0]      sat_num,
  output logic [DIV_W-1:0]         sat_den,
  output logic [QW-1:0]            val_quo
);

  localparam int NW    = QW + DIV_W;
  localparam int VAL_C = PCT * (1 << FRAC_BITS);
  localparam int VAL_A = VAL_C / CHAN_FULL;
  localparam int VAL_B = VAL_C % CHAN_FULL;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  // stage 1
  logic                  s1_valid_r;
  rhsv_flags_t           s1_flags_r, s1_flags_nxt;
  logic [CHAN_W-1:0]     s1_mx_r, s1_mx_nxt;
  logic [CHAN_W-1:0]     s1_diff_r, s1_diff_nxt;
  logic signed [CHAN_W:0] s1_num_r, s1_num_nxt;
  sector_t               s1_sec_r, s1_sec_nxt;
  logic [CHAN_W-1:0]     mn;

  always_comb begin
    // ties: red first, then green
    if (in_red >= in_green && in_red >= in_blue) begin
      s1_sec_nxt = SEC_RED;
      s1_mx_nxt  = in_red;
      s1_num_nxt = $signed({1'b0, in_green}) - $signed({1'b0, in_blue});
    end else if (in_green >= in_blue) begin
      s1_sec_nxt = SEC_GREEN;
      s1_mx_nxt  = in_green;
      s1_num_nxt = $signed({1'b0, in_blue}) - $signed({1'b0, in_red});
    end else begin
      s1_sec_nxt = SEC_BLUE;
      s1_mx_nxt  = in_blue;
      s1_num_nxt = $signed({1'b0, in_red}) - $signed({1'b0, in_green});
    end
    mn = (in_red <= in_green) ? in_red : in_green;
    if (in_blue < mn) begin
      mn = in_blue;
    end
    s1_diff_nxt           = s1_mx_nxt - mn;
    s1_flags_nxt.hue_zero = (s1_diff_nxt == '0);
    s1_flags_nxt.sat_zero = (s1_mx_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_valid;
    end
    if (en) begin
      s1_flags_r <= s1_flags_nxt;
      s1_mx_r    <= s1_mx_nxt;
      s1_diff_r  <= s1_diff_nxt;
      s1_num_r   <= s1_num_nxt;
      s1_sec_r   <= s1_sec_nxt;
    end
  end

  // stage 2: hue numerator is S * (off * diff + 60 * num)
  logic [8:0]         off_c;
  logic [16:0]        off_prod;
  logic signed [18:0] span_prod;
  logic signed [18:0] hue_base;
  logic [15:0]        val_lo;
  logic [16:0]        val_fold;

  logic               s2_valid_r;
  rhsv_flags_t        s2_flags_r;
  logic [NW-1:0]      s2_hue_num_r, s2_hue_num_nxt;
  logic [DIV_W-1:0]   s2_hue_den_r;
  logic [NW-1:0]      s2_sat_num_r, s2_sat_num_nxt;
  logic [DIV_W-1:0]   s2_sat_den_r;
  logic [QW-1:0]      s2_val_r, s2_val_nxt;

  always_comb begin
    unique case (s1_sec_r)
      SEC_RED:   off_c = 9'(OFF_RED);
      SEC_GREEN: off_c = 9'(OFF_GREEN);
      SEC_BLUE:  off_c = 9'(OFF_BLUE);
      default:   off_c = 9'(OFF_BLUE);
    endcase
    off_prod       = 17'(off_c * s1_diff_r);
    span_prod      = 19'(s1_num_r) * 19'(HUE_SPAN);
    hue_base       = $signed({2'b00, off_prod}) + span_prod;
    // positive whenever diff is nonzero
    s2_hue_num_nxt = NW'(hue_base[16:0]) << FRAC_BITS;
    s2_sat_num_nxt = NW'(15'(s1_diff_r * PCT)) << FRAC_BITS;
    // mx * (255 a + b) / 255 = mx * a + mx * b / 255, and mx * b stays below 2^16
    val_lo         = 16'(s1_mx_r * VAL_B);
    val_fold       = 17'(val_lo) + 17'(val_lo[15:8]) + 17'd1;
    s2_val_nxt     = QW'(s1_mx_r * VAL_A) + QW'(val_fold[16:8]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid_r;
    end
    if (en) begin
      s2_flags_r   <= s1_flags_r;
      s2_hue_num_r <= s2_hue_num_nxt;
      s2_hue_den_r <= s1_diff_r;
      s2_sat_num_r <= s2_sat_num_nxt;
      s2_sat_den_r <= s1_mx_r;
      s2_val_r     <= s2_val_nxt;
    end
  end

  assign op_valid = s2_valid_r;
  assign op_flags = s2_flags_r;
  assign hue_num  = s2_hue_num_r;
  assign hue_den  = s2_hue_den_r;
  assign sat_num  = s2_sat_num_r;
  assign sat_den  = s2_sat_den_r;
  assign val_quo  = s2_val_r;

endmodule

@@ rtl/rhsv_div.sv @@
// pipelined restoring divider, one quotient bit per register stage
// needs num < den * 2^QW; depends on rhsv_pkg
module rhsv_div
  import rhsv_pkg::*;
#(
  parameter int QW = 15
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [QW+DIV_W-1:0]   num,
  input  logic [DIV_W-1:0]      den,
  output logic [QW-1:0]         quo
);

  // partial remainder and divisor of every stage but the last
  logic [DIV_W-1:0] rem_r [QW-1];
  logic [DIV_W-1:0] den_r [QW-1];
  // dividend bits still to go shift out the top, quotient bits shift in below
  logic [QW-1:0]    sh_r  [QW];

  for (genvar i = 0; i < QW; i++) begin : g_step
    logic [DIV_W-1:0] rem_in;
    logic [DIV_W-1:0] den_in;
    logic [QW-1:0]    sh_in;
    logic [DIV_W:0]   trial;
    logic             qbit;
    logic [QW-1:0]    sh_nxt;

    if (i == 0) begin : g_first
      assign rem_in = num[QW+DIV_W-1:QW];
      assign den_in = den;
      assign sh_in  = num[QW-1:0];
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign den_in = den_r[i-1];
      assign sh_in  = sh_r[i-1];
    end

    assign trial  = {rem_in, sh_in[QW-1]};
    assign qbit   = (trial >= {1'b0, den_in});
    assign sh_nxt = {sh_in[QW-2:0], qbit};

    always_ff @(posedge clk) begin
      if (en) begin
        sh_r[i] <= sh_nxt;
      end
    end

    if (i < QW-1) begin : g_rem
      logic [DIV_W-1:0] rem_nxt;
      assign rem_nxt = qbit ? DIV_W'(trial - {1'b0, den_in}) : trial[DIV_W-1:0];
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i] <= rem_nxt;
          den_r[i] <= den_in;
        end
      end
    end
  end

  assign quo = sh_r[QW-1];

endmodule

@@ rtl/rgb_to_hsv_converter_top.sv @@
// rgb to hsv converter, top level: front end, two dividers, output stage
// depends on rhsv_pkg, rhsv_front, rhsv_div
// pipeline order: front end, divider stages, output register; QW = clog2(420 * 2^FRAC_BITS)
// throughput: one pixel per cycle; every stage moves on one enable, which
// holds only while a result sits in the output register and out_stall is high
// reset: synchronous active low, clears the valid bits of all stages
module rgb_to_hsv_converter_top
  import rhsv_pkg::*;
#(
  parameter int FRAC_BITS = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CHAN_W-1:0] in_red,
  input  logic [CHAN_W-1:0] in_green,
  input  logic [CHAN_W-1:0] in_blue,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [HUE_W-1:0]  out_hue,
  output logic [SV_W-1:0]   out_saturation,
  output logic [SV_W-1:0]   out_brightness
);

  localparam int QW = $clog2(HUE_QMAX_DEG * (1 << FRAC_BITS));
  localparam int NW = QW + DIV_W;
  localparam logic [QW-1:0] HUE_WRAP = QW'(HUE_WRAP_DEG * (1 << FRAC_BITS));

  logic en;
  logic out_valid_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  logic              op_valid;
  rhsv_flags_t       op_flags;
  logic [NW-1:0]     hue_num, sat_num;
  logic [DIV_W-1:0]  hue_den, sat_den;
  logic [QW-1:0]     val_quo;

  rhsv_front #(
    .FRAC_BITS (FRAC_BITS),
    .QW        (QW)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_red   (in_red),
    .in_green (in_green),
    .in_blue  (in_blue),
    .op_valid (op_valid),
    .op_flags (op_flags),
    .hue_num  (hue_num),
    .hue_den  (hue_den),
    .sat_num  (sat_num),
    .sat_den  (sat_den),
    .val_quo  (val_quo)
  );

  logic [QW-1:0] hue_q, sat_q, val_q;

  rhsv_div #(.QW(QW)) u_div_hue (
    .clk (clk), .en (en), .num (hue_num), .den (hue_den), .quo (hue_q)
  );

  rhsv_div #(.QW(QW)) u_div_sat (
    .clk (clk), .en (en), .num (sat_num), .den (sat_den), .quo (sat_q)
  );

  // valid bits, flags and brightness ride alongside the divider stages
  logic          vld_pipe_r [QW];
  rhsv_flags_t   flg_pipe_r [QW];
  logic [QW-1:0] val_pipe_r [QW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < QW; i++) begin
        vld_pipe_r[i] <= 1'b0;
      end
    end else if (en) begin
      vld_pipe_r[0] <= op_valid;
      for (int i = 1; i < QW; i++) begin
        vld_pipe_r[i] <= vld_pipe_r[i-1];
      end
    end
    if (en) begin
      flg_pipe_r[0] <= op_flags;
      val_pipe_r[0] <= val_quo;
      for (int i = 1; i < QW; i++) begin
        flg_pipe_r[i] <= flg_pipe_r[i-1];
        val_pipe_r[i] <= val_pipe_r[i-1];
      end
    end
  end

  assign val_q = val_pipe_r[QW-1];

  // output stage: hue wrap, forced zeros, field masking
  rhsv_flags_t           fin_flags;
  logic [QW-1:0]         hue_wrapped;
  logic [QW+HUE_W-1:0]   hue_ext;
  logic [QW+SV_W-1:0]    sat_ext, val_ext;
  logic [HUE_W-1:0]      out_hue_r, out_hue_nxt;
  logic [SV_W-1:0]       out_sat_r, out_sat_nxt;
  logic [SV_W-1:0]       out_bri_r, out_bri_nxt;

  always_comb begin
    fin_flags   = flg_pipe_r[QW-1];
    hue_wrapped = (hue_q >= HUE_WRAP) ? QW'(hue_q - HUE_WRAP) : hue_q;
    hue_ext     = {{HUE_W{1'b0}}, hue_wrapped};
    sat_ext     = {{SV_W{1'b0}}, sat_q};
    val_ext     = {{SV_W{1'b0}}, val_q};
    out_hue_nxt = fin_flags.hue_zero ? '0 : hue_ext[HUE_W-1:0];
    out_sat_nxt = fin_flags.sat_zero ? '0 : sat_ext[SV_W-1:0];
    out_bri_nxt = val_ext[SV_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_pipe_r[QW-1];
    end
    if (en) begin
      out_hue_r <= out_hue_nxt;
      out_sat_r <= out_sat_nxt;
      out_bri_r <= out_bri_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hue        = out_hue_r;
  assign out_saturation = out_sat_r;
  assign out_brightness = out_bri_r;

  // a black pixel is always grey as well
  a_black_is_grey: assert property (@(posedge clk) disable iff (!rst_n)
    op_valid && op_flags.sat_zero |-> op_flags.hue_zero)
    else $error("black pixel without grey flag");

  // no result right after reset
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a held result stays put and blocks the input
  a_hold_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_hue) && (in_stall == out_stall))
    else $error("held result lost or input not blocked");

  // the last divider stage feeds the output register on every move
  a_valid_follow: assert property (@(posedge clk) disable iff (!rst_n)
    en && vld_pipe_r[QW-1] |=> out_valid)
    else $error("transaction lost at output stage");

endmodule
